// ----- src/its_pkg.sv -----
package its_pkg;

  // Input beat: object position, object velocity, tool position (signed Q8.16)
  typedef struct packed {
    logic signed [23:0] obj_pos_x;
    logic signed [23:0] obj_pos_y;
    logic signed [23:0] obj_pos_z;
    logic signed [23:0] obj_vel_x;
    logic signed [23:0] obj_vel_y;
    logic signed [23:0] obj_vel_z;
    logic signed [23:0] tool_pos_x;
    logic signed [23:0] tool_pos_y;
    logic signed [23:0] tool_pos_z;
  } in_t;

  // Output beat: meeting time (unsigned Q8.16) and found flag
  typedef struct packed {
    logic [23:0] meet_time;
    logic        found;
  } out_t;

  localparam int SpeedW  = 23;
  localparam int RootW   = 52;
  localparam int RadW    = 2 * RootW;
  localparam int SqRemW  = RootW + 4;
  localparam int QuoW    = 24;
  localparam int DivRemW = 74;
  localparam logic [QuoW-1:0] TimeMax = '1;

  // How the time is formed for one beat
  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_ZERO,
    MODE_LIN,
    MODE_CLOSED,
    MODE_OPEN
  } mode_t;

  // Beat state inside the square root pipeline
  typedef struct packed {
    logic              valid;
    mode_t             mode;
    logic [49:0]       absb;
    logic              bneg;
    logic [48:0]       absa2;
    logic [49:0]       c;
    logic [RadW-1:0]   x;
    logic [SqRemW-1:0] rem;
    logic [RootW-1:0]  root;
  } sq_t;

  // Beat state inside the divide pipeline
  typedef struct packed {
    logic               valid;
    logic               found;
    logic               zero;
    logic               sat;
    logic [DivRemW-1:0] rem;
    logic [49:0]        q;
    logic [QuoW-1:0]    quo;
  } dv_t;

endpackage

// ----- src/intercept_time_solver.sv -----
// Intercept time solver: earliest meeting time of a tool at top speed with a moving object.
// Pipeline: 6 setup stages, 52 square root stages, one numerator stage, 24 divide
// stages and an output register.
// Throughput: one beat per cycle; the whole pipeline holds while an output beat waits.
// Reset: rst (synchronous) clears all valid bits and sets max_speed to 1.0 m/s.
module intercept_time_solver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [its_pkg::SpeedW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  its_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output its_pkg::out_t               out_data
);

  logic en;
  logic [its_pkg::SpeedW-1:0] max_speed;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Hold the speed register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= its_pkg::SpeedW'(65536);
    end else if (cfg_we) begin
      max_speed <= cfg_data;
    end
  end

  // Stage 1: relative position
  logic               s1_v;
  logic signed [24:0] s1_d [3];
  logic signed [23:0] s1_vel [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d[0]   <= $signed({in_data.obj_pos_x[23], in_data.obj_pos_x})
                 - $signed({in_data.tool_pos_x[23], in_data.tool_pos_x});
      s1_d[1]   <= $signed({in_data.obj_pos_y[23], in_data.obj_pos_y})
                 - $signed({in_data.tool_pos_y[23], in_data.tool_pos_y});
      s1_d[2]   <= $signed({in_data.obj_pos_z[23], in_data.obj_pos_z})
                 - $signed({in_data.tool_pos_z[23], in_data.tool_pos_z});
      s1_vel[0] <= in_data.obj_vel_x;
      s1_vel[1] <= in_data.obj_vel_y;
      s1_vel[2] <= in_data.obj_vel_z;
    end
  end

  // Stage 2: per-axis products
  logic               s2_v;
  logic signed [49:0] s2_dd [3];
  logic signed [48:0] s2_dv [3];
  logic signed [47:0] s2_vv [3];
  logic [45:0]        s2_ms2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_dd[i] <= s1_d[i] * s1_d[i];
        s2_dv[i] <= s1_d[i] * s1_vel[i];
        s2_vv[i] <= s1_vel[i] * s1_vel[i];
      end
      s2_ms2 <= max_speed * max_speed;
    end
  end

  // Stage 3: quadratic coefficients
  logic               s3_v;
  logic [49:0]        s3_c;
  logic signed [51:0] s3_b;
  logic signed [49:0] s3_a;
  logic signed [51:0] csum;
  logic signed [50:0] bsum;
  logic signed [49:0] asum;

  assign csum = 52'(s2_dd[0]) + 52'(s2_dd[1]) + 52'(s2_dd[2]);
  assign bsum = 51'(s2_dv[0]) + 51'(s2_dv[1]) + 51'(s2_dv[2]);
  assign asum = 50'(s2_vv[0]) + 50'(s2_vv[1]) + 50'(s2_vv[2]) - $signed({4'b0, s2_ms2});

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_c <= csum[49:0];
      s3_b <= {bsum, 1'b0};
      s3_a <= asum;
    end
  end

  // Stage 4: magnitudes, sign and zero flags, and partial products of B^2 and |A|C
  logic        s4_v;
  logic [49:0] s4_absb;
  logic [47:0] s4_absa;
  logic [49:0] s4_c;
  logic        s4_bneg, s4_bzero, s4_aneg, s4_azero, s4_czero;
  logic [49:0] s4_bhh, s4_bhl, s4_bll;
  logic [48:0] s4_ahch, s4_ahcl;
  logic [48:0] s4_alch, s4_alcl;
  logic [51:0] absb_w;
  logic [49:0] absa_w;

  assign absb_w = s3_b[51] ? 52'(-s3_b) : 52'(s3_b);
  assign absa_w = s3_a[49] ? 50'(-s3_a) : 50'(s3_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_absb  <= absb_w[49:0];
      s4_absa  <= absa_w[47:0];
      s4_c     <= s3_c;
      s4_bneg  <= s3_b[51];
      s4_bzero <= (s3_b == '0);
      s4_aneg  <= s3_a[49];
      s4_azero <= (s3_a == '0);
      s4_czero <= (s3_c == '0);
      s4_bhh   <= absb_w[49:25] * absb_w[49:25];
      s4_bhl   <= absb_w[49:25] * absb_w[24:0];
      s4_bll   <= absb_w[24:0] * absb_w[24:0];
      s4_ahch  <= absa_w[47:24] * s3_c[49:25];
      s4_ahcl  <= absa_w[47:24] * s3_c[24:0];
      s4_alch  <= absa_w[23:0] * s3_c[49:25];
      s4_alcl  <= absa_w[23:0] * s3_c[24:0];
    end
  end

  // Stage 5: combine partial products into B^2 and 4|A|C
  logic         s5_v;
  logic [101:0] s5_bb, s5_fac;
  logic [49:0]  s5_absb;
  logic [47:0]  s5_absa;
  logic [49:0]  s5_c;
  logic         s5_bneg, s5_bzero, s5_aneg, s5_azero, s5_czero;
  logic [101:0] ac_w;

  assign ac_w = (102'(s4_ahch) << 49) + (102'(s4_ahcl) << 24)
              + (102'(s4_alch) << 25) + 102'(s4_alcl);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_bb    <= (102'(s4_bhh) << 50) + (102'(s4_bhl) << 26) + 102'(s4_bll);
      s5_fac   <= ac_w << 2;
      s5_absb  <= s4_absb;
      s5_absa  <= s4_absa;
      s5_c     <= s4_c;
      s5_bneg  <= s4_bneg;
      s5_bzero <= s4_bzero;
      s5_aneg  <= s4_aneg;
      s5_azero <= s4_azero;
      s5_czero <= s4_czero;
    end
  end

  // Stage 6: pick the case and form the discriminant
  its_pkg::mode_t mode_w;
  logic [101:0]   disc_w;
  its_pkg::sq_t   sq [53];

  always_comb begin
    mode_w = its_pkg::MODE_NONE;
    disc_w = '0;
    if (s5_azero) begin
      if (s5_bneg) begin
        mode_w = its_pkg::MODE_LIN;
      end else if (!s5_bzero && s5_czero) begin
        mode_w = its_pkg::MODE_ZERO;
      end
    end else if (!s5_aneg) begin
      if (s5_bb >= s5_fac) begin
        if (s5_bneg || s5_bzero) begin
          mode_w = its_pkg::MODE_CLOSED;
          disc_w = s5_bb - s5_fac;
        end else if (s5_czero) begin
          mode_w = its_pkg::MODE_ZERO;
        end
      end
    end else begin
      if (s5_czero && !s5_bneg) begin
        mode_w = its_pkg::MODE_ZERO;
      end else begin
        mode_w = its_pkg::MODE_OPEN;
        disc_w = s5_bb + s5_fac;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].valid <= 1'b0;
    end else if (en) begin
      sq[0].valid <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].mode  <= mode_w;
      sq[0].absb  <= s5_absb;
      sq[0].bneg  <= s5_bneg;
      sq[0].absa2 <= {s5_absa, 1'b0};
      sq[0].c     <= s5_c;
      sq[0].x     <= {2'b00, disc_w};
      sq[0].rem   <= '0;
      sq[0].root  <= '0;
    end
  end

  // Square root: one root bit per stage
  for (genvar j = 0; j < its_pkg::RootW; j++) begin : g_sqrt
    logic [its_pkg::SqRemW-1:0] rem_sh, trial;
    logic                       take;

    assign rem_sh = {sq[j].rem[its_pkg::SqRemW-3:0], sq[j].x[its_pkg::RadW-1 -: 2]};
    assign trial  = its_pkg::SqRemW'({sq[j].root, 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq[j+1].valid <= 1'b0;
      end else if (en) begin
        sq[j+1].valid <= sq[j].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[j+1].mode  <= sq[j].mode;
        sq[j+1].absb  <= sq[j].absb;
        sq[j+1].bneg  <= sq[j].bneg;
        sq[j+1].absa2 <= sq[j].absa2;
        sq[j+1].c     <= sq[j].c;
        sq[j+1].x     <= {sq[j].x[its_pkg::RadW-3:0], 2'b00};
        sq[j+1].rem   <= take ? rem_sh - trial : rem_sh;
        sq[j+1].root  <= {sq[j].root[its_pkg::RootW-2:0], take};
      end
    end
  end

  // Numerator and divisor stage, with saturation check
  its_pkg::sq_t sqo;
  logic [52:0]  num_w;
  logic [49:0]  den_w;
  its_pkg::dv_t dv [its_pkg::QuoW+1];

  assign sqo = sq[its_pkg::RootW];

  always_comb begin
    case (sqo.mode)
      its_pkg::MODE_LIN: begin
        num_w = 53'(sqo.c);
        den_w = sqo.absb;
      end
      its_pkg::MODE_CLOSED: begin
        num_w = 53'(sqo.absb) - 53'(sqo.root);
        den_w = 50'(sqo.absa2);
      end
      its_pkg::MODE_OPEN: begin
        num_w = sqo.bneg ? 53'(sqo.root) - 53'(sqo.absb) : 53'(sqo.root) + 53'(sqo.absb);
        den_w = 50'(sqo.absa2);
      end
      default: begin
        num_w = '0;
        den_w = 50'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (en) begin
      dv[0].valid <= sqo.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].found <= (sqo.mode != its_pkg::MODE_NONE);
      dv[0].zero  <= (sqo.mode == its_pkg::MODE_ZERO);
      dv[0].sat   <= 58'(num_w) >= (58'(den_w) << 8);
      dv[0].rem   <= its_pkg::DivRemW'(num_w) << 16;
      dv[0].q     <= den_w;
      dv[0].quo   <= '0;
    end
  end

  // Long division: one quotient bit per stage, most significant first
  for (genvar j = 0; j < its_pkg::QuoW; j++) begin : g_div
    localparam int K = its_pkg::QuoW - 1 - j;
    logic [its_pkg::DivRemW-1:0] qs;
    logic                        take;

    assign qs   = its_pkg::DivRemW'(dv[j].q) << K;
    assign take = dv[j].rem >= qs;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1].valid <= 1'b0;
      end else if (en) begin
        dv[j+1].valid <= dv[j].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1].found <= dv[j].found;
        dv[j+1].zero  <= dv[j].zero;
        dv[j+1].sat   <= dv[j].sat;
        dv[j+1].q     <= dv[j].q;
        dv[j+1].rem   <= take ? dv[j].rem - qs : dv[j].rem;
        dv[j+1].quo   <= dv[j].quo | (its_pkg::QuoW'(take) << K);
      end
    end
  end

  // Output register
  its_pkg::dv_t dvo;
  assign dvo = dv[its_pkg::QuoW];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dvo.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.found <= dvo.found;
      if (!dvo.found || dvo.zero) begin
        out_data.meet_time <= '0;
      end else if (dvo.sat) begin
        out_data.meet_time <= its_pkg::TimeMax;
      end else begin
        out_data.meet_time <= dvo.quo;
      end
    end
  end

endmodule
